FILE: rtl/rcmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTS/CTS MAC handshake package
// Shared types and constants for the RTS/CTS/DATA/ACK handshake controller.
// ----------------------------------------------------------------------------
package rcmh_pkg;

    // Width of the saturating tick counters for control and report ages.
    localparam int AGE_BITS   = 16;
    localparam int PERIOD_W   = 16;
    // Common width used when an age is compared against a period.
    localparam int AGE_CMP_W  = (AGE_BITS > PERIOD_W) ? AGE_BITS : PERIOD_W;

    localparam int ADDR_W     = 8;
    localparam int FTYPE_W    = 3;
    localparam int WAIT_W     = 8;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Handshake mode, also reported on every result.
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CTS_WAIT  = 2'd1,
        MODE_DATA_WAIT = 2'd2,
        MODE_ACK_WAIT  = 2'd3
    } mode_t;

    // Frame type codes.
    localparam logic [FTYPE_W-1:0] FR_RTS    = 3'd0;
    localparam logic [FTYPE_W-1:0] FR_CTS    = 3'd1;
    localparam logic [FTYPE_W-1:0] FR_DATA   = 3'd2;
    localparam logic [FTYPE_W-1:0] FR_ACK    = 3'd3;
    localparam logic [FTYPE_W-1:0] FR_BEACON = 3'd4;
    localparam logic [FTYPE_W-1:0] FR_BCAST  = 3'd5;
    localparam logic [FTYPE_W-1:0] FR_NONE   = 3'd0;

    localparam logic [ADDR_W-1:0] BCAST_ADDR = 8'd255;
    localparam logic [ADDR_W-1:0] NO_ADDR    = 8'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HOST_ADDR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEACON_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 2'd3;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0]   HOST_ADDR_RST     = 8'd0;
    localparam logic [WAIT_W-1:0]   WAIT_LIMIT_RST    = 8'd100;
    localparam logic [PERIOD_W-1:0] BEACON_PERIOD_RST = 16'd500;
    localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RST = 16'd500;

endpackage

FILE: rtl/rts_cts_mac_handshake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTS/CTS MAC handshake controller
// One poll tick per request: answers RTS with CTS, sends RTS, DATA, ACK,
// broadcast data and beacons, times out waits and paces application reports.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one poll tick per request, holding the
//   received frame header and the router status. m_tvalid/m_tready/m_tdata
//   return exactly one result per tick: the frame to send, the router and
//   application strobes and the mode after the tick.
//   cfg_we/cfg_index/cfg_wdata write the four registers (host address, wait
//   limit, beacon period, report period); write only while the block is idle.
// Timing and throughput:
//   A tick's result is registered and shows on m_tvalid the cycle after it is
//   accepted. One tick is taken every cycle while s_tready is high; the
//   handshake state and both age counters update as the tick is accepted.
// Reset:
//   aresetn low returns the mode to idle, clears the wait counter, the peer
//   address and both ages, and restores the register defaults.
// Stalls:
//   While a result waits with m_tready low, s_tready drops and no new tick
//   is taken; when the result is taken, a new tick can be accepted the same
//   cycle.
// ----------------------------------------------------------------------------
module rts_cts_mac_handshake
    import rcmh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Tick request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: rx_valid[0], rx_type[3:1], rx_src[11:4], rx_dst[19:12],
    // have_packet[20], route_ok[21], route_dest[29:22], zero fill [31:30]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: tx_valid[0], tx_type[3:1], tx_dst[11:4], deliver_frame[12],
    // absorb_beacon[13], take_packet[14], report_app[15], mac_mode[17:16],
    // zero fill [23:18]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // Configuration registers
    logic [ADDR_W-1:0]   host_addr_reg;
    logic [WAIT_W-1:0]   wait_limit_reg;
    logic [PERIOD_W-1:0] beacon_period_reg;
    logic [PERIOD_W-1:0] report_period_reg;

    // Handshake state
    mode_t               mode_reg, mode_next;
    logic [WAIT_W-1:0]   wait_count_reg, wait_count_next;
    logic [ADDR_W-1:0]   peer_addr_reg, peer_addr_next;
    logic [AGE_BITS-1:0] ctrl_age_reg, ctrl_age_next;
    logic [AGE_BITS-1:0] report_age_reg, report_age_next;

    // Result register
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Unpacked request fields
    logic                rx_valid;
    logic [FTYPE_W-1:0]  rx_type;
    logic [ADDR_W-1:0]   rx_src;
    logic [ADDR_W-1:0]   rx_dst;
    logic                have_packet;
    logic                route_ok;
    logic [ADDR_W-1:0]   route_dest;

    // Per-tick working values
    logic                accept;
    logic [AGE_BITS-1:0] ctrl_inc;
    logic [AGE_BITS-1:0] report_inc;
    logic                beacon_due;
    logic                report_due;
    logic                handled;
    logic                ctrl_sent;
    logic                tx_valid;
    logic [FTYPE_W-1:0]  tx_type;
    logic [ADDR_W-1:0]   tx_dst;
    logic                deliver_frame;
    logic                absorb_beacon;
    logic                take_packet;

    assign rx_valid    = s_tdata[0];
    assign rx_type     = s_tdata[3:1];
    assign rx_src      = s_tdata[11:4];
    assign rx_dst      = s_tdata[19:12];
    assign have_packet = s_tdata[20];
    assign route_ok    = s_tdata[21];
    assign route_dest  = s_tdata[29:22];

    // A tick is taken whenever the result register is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Saturating ages and their period compares.
    assign ctrl_inc   = (ctrl_age_reg == AGE_MAX) ? ctrl_age_reg : ctrl_age_reg + 1'b1;
    assign report_inc = (report_age_reg == AGE_MAX) ? report_age_reg
                                                    : report_age_reg + 1'b1;
    assign beacon_due = AGE_CMP_W'(ctrl_inc) >= AGE_CMP_W'(beacon_period_reg);
    assign report_due = AGE_CMP_W'(report_inc) >= AGE_CMP_W'(report_period_reg);

    // Handshake decisions for one tick.
    always_comb begin
        mode_next       = mode_reg;
        wait_count_next = wait_count_reg;
        peer_addr_next  = peer_addr_reg;
        handled         = 1'b0;
        ctrl_sent       = 1'b0;
        tx_valid        = 1'b0;
        tx_type         = FR_NONE;
        tx_dst          = NO_ADDR;
        deliver_frame   = 1'b0;
        absorb_beacon   = 1'b0;
        take_packet     = 1'b0;

        if (rx_valid) begin
            // Frames expected in the current mode.
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (rx_type == FR_RTS && rx_dst == host_addr_reg) begin
                        tx_valid        = 1'b1;
                        tx_type         = FR_CTS;
                        tx_dst          = rx_src;
                        ctrl_sent       = 1'b1;
                        mode_next       = MODE_DATA_WAIT;
                        wait_count_next = '0;
                        absorb_beacon   = 1'b1;
                        handled         = 1'b1;
                    end
                end
                MODE_CTS_WAIT: begin
                    if (rx_type == FR_CTS && rx_src == peer_addr_reg &&
                        rx_dst == host_addr_reg) begin
                        take_packet     = 1'b1;
                        tx_valid        = 1'b1;
                        tx_type         = FR_DATA;
                        tx_dst          = peer_addr_reg;
                        mode_next       = MODE_ACK_WAIT;
                        wait_count_next = '0;
                        absorb_beacon   = 1'b1;
                        handled         = 1'b1;
                    end
                end
                MODE_DATA_WAIT: begin
                    if (rx_type == FR_DATA && rx_dst == host_addr_reg) begin
                        deliver_frame = 1'b1;
                        tx_valid      = 1'b1;
                        tx_type       = FR_ACK;
                        tx_dst        = rx_src;
                        mode_next     = MODE_IDLE;
                        handled       = 1'b1;
                    end
                end
                MODE_ACK_WAIT: begin
                    if (rx_type == FR_ACK && rx_dst == host_addr_reg) begin
                        mode_next = MODE_IDLE;
                        handled   = 1'b1;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
            // Beacons and broadcast data pass up in any mode.
            if (!handled) begin
                if (rx_type == FR_BEACON) begin
                    absorb_beacon = 1'b1;
                end else if (rx_type == FR_BCAST) begin
                    deliver_frame = 1'b1;
                end
            end
        end else if (mode_reg == MODE_IDLE) begin
            // Idle and quiet: route a pending packet or send a beacon.
            if (have_packet) begin
                if (route_ok) begin
                    if (route_dest != BCAST_ADDR) begin
                        tx_valid        = 1'b1;
                        tx_type         = FR_RTS;
                        tx_dst          = route_dest;
                        ctrl_sent       = 1'b1;
                        peer_addr_next  = route_dest;
                        wait_count_next = '0;
                        mode_next       = MODE_CTS_WAIT;
                    end else begin
                        take_packet = 1'b1;
                        tx_valid    = 1'b1;
                        tx_type     = FR_BCAST;
                        tx_dst      = BCAST_ADDR;
                    end
                end
            end else if (beacon_due) begin
                tx_valid  = 1'b1;
                tx_type   = FR_BEACON;
                tx_dst    = BCAST_ADDR;
                ctrl_sent = 1'b1;
            end
        end else begin
            // Quiet tick in a wait state counts towards the timeout.
            if (wait_count_reg >= wait_limit_reg) begin
                mode_next = MODE_IDLE;
            end else begin
                wait_count_next = wait_count_reg + 1'b1;
            end
        end

        ctrl_age_next   = ctrl_sent ? '0 : ctrl_inc;
        report_age_next = report_due ? '0 : report_inc;

        m_data_next = {6'd0, mode_next, report_due, take_packet, absorb_beacon,
                       deliver_frame, tx_dst, tx_type, tx_valid};
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_addr_reg     <= HOST_ADDR_RST;
            wait_limit_reg    <= WAIT_LIMIT_RST;
            beacon_period_reg <= BEACON_PERIOD_RST;
            report_period_reg <= REPORT_PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HOST_ADDR:     host_addr_reg     <= cfg_wdata[ADDR_W-1:0];
                REG_WAIT_LIMIT:    wait_limit_reg    <= cfg_wdata[WAIT_W-1:0];
                REG_BEACON_PERIOD: beacon_period_reg <= cfg_wdata;
                REG_REPORT_PERIOD: report_period_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Handshake state, updated once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            wait_count_reg <= '0;
            peer_addr_reg  <= '0;
            ctrl_age_reg   <= '0;
            report_age_reg <= '0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            wait_count_reg <= wait_count_next;
            peer_addr_reg  <= peer_addr_next;
            ctrl_age_reg   <= ctrl_age_next;
            report_age_reg <= report_age_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: bench/rts_cts_mac_handshake_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTS/CTS MAC handshake checker
// Watches the poll tick, result and register channels of the handshake
// controller. It keeps its own model of the mode, wait counter, peer address,
// ages and registers, predicts one result per accepted tick, and compares
// every accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rts_cts_mac_handshake_chk
    import rcmh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // From bit 0: rx_valid, rx_type, rx_src, rx_dst, have_packet, route_ok,
    // route_dest, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: tx_valid, tx_type, tx_dst, deliver_frame, absorb_beacon,
    // take_packet, report_app, mac_mode, zero fill
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending,
    output int                    n_results,
    output int                    n_frames,
    output int                    n_timeouts,
    output int                    n_reports
);

    localparam int MAX_REPORTS = 40;

    // Poll tick as packed on s_tdata, highest field first.
    typedef struct packed {
        logic [1:0]         fill;
        logic [ADDR_W-1:0]  route_dest;
        logic               route_ok;
        logic               have_packet;
        logic [ADDR_W-1:0]  rx_dst;
        logic [ADDR_W-1:0]  rx_src;
        logic [FTYPE_W-1:0] rx_type;
        logic               rx_valid;
    } poll_tick_t;

    // Result as packed on m_tdata, highest field first.
    typedef struct packed {
        logic [5:0]         fill;
        mode_t              mac_mode;
        logic               report_app;
        logic               take_packet;
        logic               absorb_beacon;
        logic               deliver_frame;
        logic [ADDR_W-1:0]  tx_dst;
        logic [FTYPE_W-1:0] tx_type;
        logic               tx_valid;
    } mac_result_t;

    // Register copies.
    logic [ADDR_W-1:0]   host;
    logic [WAIT_W-1:0]   wait_lim;
    logic [PERIOD_W-1:0] beacon_per;
    logic [PERIOD_W-1:0] report_per;

    // Handshake state.
    mode_t               cur_mode;
    logic [WAIT_W-1:0]   wait_cnt;
    logic [ADDR_W-1:0]   peer;
    logic [AGE_BITS-1:0] ctrl_age;
    logic [AGE_BITS-1:0] report_age;

    mac_result_t due_results[$];

    // Works out the result of one poll tick and advances the state.
    function automatic mac_result_t mac_tick(input poll_tick_t t);
        mac_result_t r;
        logic        ctrl_sent;
        logic        handled;
        r         = '0;
        ctrl_sent = 1'b0;
        handled   = 1'b0;

        // Both ages count every tick and stop at their maximum.
        if (ctrl_age != {AGE_BITS{1'b1}})
            ctrl_age = ctrl_age + 1'b1;
        if (report_age != {AGE_BITS{1'b1}})
            report_age = report_age + 1'b1;

        if (t.rx_valid) begin
            if (cur_mode == MODE_IDLE && t.rx_type == FR_RTS && t.rx_dst == host) begin
                // Answer an RTS for us with a CTS and wait for the data.
                r.tx_valid      = 1'b1;
                r.tx_type       = FR_CTS;
                r.tx_dst        = t.rx_src;
                r.absorb_beacon = 1'b1;
                ctrl_sent       = 1'b1;
                cur_mode        = MODE_DATA_WAIT;
                wait_cnt        = '0;
                handled         = 1'b1;
            end else if (cur_mode == MODE_CTS_WAIT && t.rx_type == FR_CTS &&
                         t.rx_src == peer && t.rx_dst == host) begin
                // Clear to send from our peer: the packet goes out as data.
                r.take_packet   = 1'b1;
                r.tx_valid      = 1'b1;
                r.tx_type       = FR_DATA;
                r.tx_dst        = peer;
                r.absorb_beacon = 1'b1;
                cur_mode        = MODE_ACK_WAIT;
                wait_cnt        = '0;
                handled         = 1'b1;
            end else if (cur_mode == MODE_DATA_WAIT && t.rx_type == FR_DATA &&
                         t.rx_dst == host) begin
                r.deliver_frame = 1'b1;
                r.tx_valid      = 1'b1;
                r.tx_type       = FR_ACK;
                r.tx_dst        = t.rx_src;
                cur_mode        = MODE_IDLE;
                handled         = 1'b1;
            end else if (cur_mode == MODE_ACK_WAIT && t.rx_type == FR_ACK &&
                         t.rx_dst == host) begin
                cur_mode = MODE_IDLE;
                handled  = 1'b1;
            end
            // Beacons and broadcast data are taken in any mode.
            if (!handled) begin
                if (t.rx_type == FR_BEACON)
                    r.absorb_beacon = 1'b1;
                else if (t.rx_type == FR_BCAST)
                    r.deliver_frame = 1'b1;
            end
        end else if (cur_mode == MODE_IDLE) begin
            if (t.have_packet) begin
                if (t.route_ok) begin
                    if (t.route_dest != BCAST_ADDR) begin
                        r.tx_valid = 1'b1;
                        r.tx_type  = FR_RTS;
                        r.tx_dst   = t.route_dest;
                        ctrl_sent  = 1'b1;
                        peer       = t.route_dest;
                        wait_cnt   = '0;
                        cur_mode   = MODE_CTS_WAIT;
                    end else begin
                        r.take_packet = 1'b1;
                        r.tx_valid    = 1'b1;
                        r.tx_type     = FR_BCAST;
                        r.tx_dst      = BCAST_ADDR;
                    end
                end
            end else if (ctrl_age >= beacon_per) begin
                r.tx_valid = 1'b1;
                r.tx_type  = FR_BEACON;
                r.tx_dst   = BCAST_ADDR;
                ctrl_sent  = 1'b1;
            end
        end else begin
            // A frameless tick in a wait state counts toward the timeout.
            if (wait_cnt >= wait_lim) begin
                cur_mode   = MODE_IDLE;
                n_timeouts = n_timeouts + 1;
            end else begin
                wait_cnt = wait_cnt + 1'b1;
            end
        end

        if (ctrl_sent)
            ctrl_age = '0;

        if (report_age >= report_per) begin
            r.report_app = 1'b1;
            report_age   = '0;
        end

        r.mac_mode = cur_mode;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result %0d, %s expected %0h, got %0h",
                         $time, n_results, fname, want, got);
        end
    endtask

    // Compare, then take register writes, then predict for the new tick.
    always @(posedge aclk) begin
        mac_result_t want;
        mac_result_t got;
        if (!aresetn) begin
            host       = HOST_ADDR_RST;
            wait_lim   = WAIT_LIMIT_RST;
            beacon_per = BEACON_PERIOD_RST;
            report_per = REPORT_PERIOD_RST;
            cur_mode   = MODE_IDLE;
            wait_cnt   = '0;
            peer       = '0;
            ctrl_age   = '0;
            report_age = '0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = mac_result_t'(m_tdata);
                if (due_results.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result %0h arrived with none expected",
                                 $time, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_type", want.tx_type, got.tx_type);
                    check_field("tx_dst", want.tx_dst, got.tx_dst);
                    check_field("deliver_frame", want.deliver_frame, got.deliver_frame);
                    check_field("absorb_beacon", want.absorb_beacon, got.absorb_beacon);
                    check_field("take_packet", want.take_packet, got.take_packet);
                    check_field("report_app", want.report_app, got.report_app);
                    check_field("mac_mode", want.mac_mode, got.mac_mode);
                    check_field("zero fill", want.fill, got.fill);
                    n_results = n_results + 1;
                    if (want.tx_valid)
                        n_frames = n_frames + 1;
                    if (want.report_app)
                        n_reports = n_reports + 1;
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    REG_HOST_ADDR:     host       = cfg_wdata[ADDR_W-1:0];
                    REG_WAIT_LIMIT:    wait_lim   = cfg_wdata[WAIT_W-1:0];
                    REG_BEACON_PERIOD: beacon_per = cfg_wdata[PERIOD_W-1:0];
                    REG_REPORT_PERIOD: report_per = cfg_wdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                due_results.push_back(mac_tick(poll_tick_t'(s_tdata)));
        end
        pending = due_results.size();
    end

endmodule

FILE: bench/rts_cts_mac_handshake_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTS/CTS MAC handshake testbench
// Drives poll ticks into the handshake controller: a short directed run at
// the reset settings, then random inbound and outbound exchanges, routing
// requests, quiet stretches and noise frames under several register
// settings. Sender gaps and receiver stalls are random; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module rts_cts_mac_handshake_tb;
    import rcmh_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int TICKS_PER_PHASE = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // From bit 0: rx_valid, rx_type, rx_src, rx_dst, have_packet, route_ok,
    // route_dest, zero fill
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // From bit 0: tx_valid, tx_type, tx_dst, deliver_frame, absorb_beacon,
    // take_packet, report_app, mac_mode, zero fill
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int n_results;
    int n_frames;
    int n_timeouts;
    int n_reports;

    int          n_ticks;
    int          burst_left;
    int          quiet_cycles;
    logic        steady;
    logic [7:0]  cur_host;

    rts_cts_mac_handshake dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rts_cts_mac_handshake_chk chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .n_results  (n_results),
        .n_frames   (n_frames),
        .n_timeouts (n_timeouts),
        .n_reports  (n_reports)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Packs one poll tick into the s_tdata layout.
    function automatic logic [S_TDATA_W-1:0] pack_tick(
        input logic rxv, input logic [2:0] rtype, input logic [7:0] src,
        input logic [7:0] dst, input logic have, input logic ok,
        input logic [7:0] dest);
        return {2'b00, dest, ok, have, dst, src, rtype, rxv};
    endfunction

    // A received frame header; the router status never routes (route_ok low).
    function automatic logic [S_TDATA_W-1:0] frame_tick(
        input logic [2:0] rtype, input logic [7:0] src, input logic [7:0] dst);
        return pack_tick(1'b1, rtype, src, dst, 1'($urandom_range(0, 1)), 1'b0,
                         8'($urandom));
    endfunction

    // No frame and no successful routing: junk in the ignored fields.
    function automatic logic [S_TDATA_W-1:0] quiet_tick();
        return pack_tick(1'b0, 3'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'b0, 8'($urandom));
    endfunction

    function automatic logic [7:0] some_dst();
        return ($urandom_range(0, 3) != 0) ? cur_host : 8'($urandom);
    endfunction

    // Sends one tick, opening a random gap at the start of some bursts outside steady phases.
    task automatic send_tick(input logic [S_TDATA_W-1:0] word);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
        end
        burst_left = burst_left - 1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_ticks = n_ticks + 1;
        @(negedge aclk);
    endtask

    // Stops the ticks and lets every pending result drain out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Writes all four registers on consecutive cycles.
    task automatic program_regs(input logic [7:0] host, input logic [7:0] wlim,
                                input logic [15:0] bper, input logic [15:0] rper);
        cur_host  = host;
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOST_ADDR;
        cfg_wdata <= {8'($urandom), host};
        @(negedge aclk);
        cfg_index <= REG_WAIT_LIMIT;
        cfg_wdata <= {8'($urandom), wlim};
        @(negedge aclk);
        cfg_index <= REG_BEACON_PERIOD;
        cfg_wdata <= bper;
        @(negedge aclk);
        cfg_index <= REG_REPORT_PERIOD;
        cfg_wdata <= rper;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One random scenario: mostly complete exchanges, some broken, some noise.
    task automatic run_scenario();
        int         pick;
        int         n;
        logic [7:0] peer;
        pick = $urandom_range(0, 99);
        peer = 8'($urandom);
        if (pick < 25) begin
            // Peer asks us to receive: RTS, a short pause, then the data.
            send_tick(frame_tick(FR_RTS, peer, cur_host));
            n = $urandom_range(0, 3);
            repeat (n) send_tick(quiet_tick());
            if ($urandom_range(0, 6) != 0)
                send_tick(frame_tick(FR_DATA, peer, some_dst()));
        end else if (pick < 50) begin
            // We route a packet: RTS out, CTS back, data out, ACK back.
            peer = 8'($urandom_range(0, 254));
            send_tick(pack_tick(1'b0, 3'($urandom), 8'($urandom), 8'($urandom),
                                1'b1, 1'b1, peer));
            n = $urandom_range(0, 3);
            repeat (n) send_tick(quiet_tick());
            if ($urandom_range(0, 6) != 0)
                send_tick(frame_tick(FR_CTS,
                                     ($urandom_range(0, 5) != 0) ? peer : 8'($urandom),
                                     some_dst()));
            n = $urandom_range(0, 3);
            repeat (n) send_tick(quiet_tick());
            if ($urandom_range(0, 6) != 0)
                send_tick(frame_tick(FR_ACK, peer, some_dst()));
        end else if (pick < 58) begin
            send_tick(pack_tick(1'b0, 3'($urandom), 8'($urandom), 8'($urandom),
                                1'b1, 1'b1, BCAST_ADDR));
        end else if (pick < 64) begin
            // Routing fails this tick.
            send_tick(pack_tick(1'b0, 3'($urandom), 8'($urandom), 8'($urandom),
                                1'b1, 1'b0, 8'($urandom)));
        end else if (pick < 74) begin
            // Quiet stretch: lets waits time out and beacons fall due.
            n = $urandom_range(1, 16);
            repeat (n) send_tick(quiet_tick());
        end else if (pick < 82) begin
            send_tick(frame_tick(($urandom_range(0, 1) != 0) ? FR_BEACON : FR_BCAST,
                                 8'($urandom), 8'($urandom)));
        end else begin
            // Noise: any type, any address, any router status.
            send_tick(pack_tick(1'($urandom_range(0, 1)), 3'($urandom), 8'($urandom),
                                some_dst(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 8'($urandom)));
        end
    endtask

    // Receiver stalls on a random pattern, chosen anew after each stretch of random length.
    initial begin : rx_stall
        int style;
        int len;
        int period;
        int on_len;
        m_tready = 1'b0;
        forever begin
            style  = $urandom_range(0, 3);
            len    = $urandom_range(50, 300);
            period = $urandom_range(2, 9);
            on_len = $urandom_range(1, period - 1);
            for (int i = 0; i < len; i++) begin
                @(negedge aclk);
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ((i % period) < on_len);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d cycles without a transfer", quiet_cycles);
            $display("FAIL rts_cts_mac_handshake");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        n_ticks      = 0;
        burst_left   = 0;
        steady       = 1'b0;
        cur_host     = HOST_ADDR_RST;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed run at the reset settings (host address 0).
        send_tick(pack_tick(1'b0, FR_RTS, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_tick(frame_tick(FR_RTS, 8'h12, 8'h00));
        send_tick(frame_tick(FR_RTS, 8'h13, 8'h00));
        send_tick(frame_tick(FR_DATA, 8'h12, 8'h01));
        send_tick(frame_tick(FR_DATA, 8'h12, 8'h00));
        send_tick(pack_tick(1'b0, FR_RTS, 8'h00, 8'h00, 1'b1, 1'b1, 8'h34));
        send_tick(frame_tick(FR_CTS, 8'h77, 8'h00));
        send_tick(frame_tick(FR_BEACON, 8'h55, BCAST_ADDR));
        send_tick(frame_tick(FR_CTS, 8'h34, 8'h00));
        send_tick(frame_tick(FR_BCAST, 8'h66, BCAST_ADDR));
        send_tick(frame_tick(3'd6, 8'h34, 8'h00));
        send_tick(frame_tick(FR_ACK, 8'h34, 8'h00));
        send_tick(pack_tick(1'b0, FR_RTS, 8'h00, 8'h00, 1'b1, 1'b1, BCAST_ADDR));
        send_tick(pack_tick(1'b0, FR_RTS, 8'h00, 8'h00, 1'b1, 1'b0, 8'h34));
        send_tick(pack_tick(1'b1, 3'd7, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
        send_tick(frame_tick(FR_RTS, 8'h21, BCAST_ADDR));
        send_tick(pack_tick(1'b0, 3'd7, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'hFF));
        send_tick(frame_tick(FR_ACK, 8'h21, 8'h00));

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0:       program_regs(8'hFF, 8'd1, 16'd1, 16'd1);
                1:       program_regs(8'h00, 8'd255, 16'hFFFF, 16'hFFFF);
                default: program_regs(8'($urandom), 8'($urandom_range(1, 12)),
                                      16'($urandom_range(1, 60)),
                                      16'($urandom_range(1, 90)));
            endcase
            steady     = (ph % 3 == 2);
            burst_left = 0;
            while (n_ticks < 18 + (ph + 1) * TICKS_PER_PHASE)
                run_scenario();
        end

        settle();
        $display("Sent %0d poll ticks under %0d register settings; %0d results checked.",
                 n_ticks, NUM_PHASES + 1, n_results);
        $display("Frames sent %0d, wait timeouts %0d, application reports %0d.",
                 n_frames, n_timeouts, n_reports);
        if (fail_count == 0 && pending == 0)
            $display("PASS rts_cts_mac_handshake");
        else
            $display("FAIL rts_cts_mac_handshake");
        $finish;
    end

endmodule

FILE: files.f
rtl/rcmh_pkg.sv
rtl/rts_cts_mac_handshake.sv
bench/rts_cts_mac_handshake_chk.sv
bench/rts_cts_mac_handshake_tb.sv
